// ===== rtl/core/sbeq_pkg.sv =====
package sbeq_pkg;

  // default sizes of the datapath
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int COEF_BITS_DEF   = 32;
  localparam int NUM_STAGES_DEF  = 7;

  // fixed field widths of the channels and the configuration port
  localparam int OPC_W      = 2;
  localparam int STAGE_W    = 3;
  localparam int SLOT_W     = 3;
  localparam int COEF_IN_W  = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam int BAND_W     = 5;

  // coefficients per biquad
  localparam int NUM_SLOTS = 5;

  // first stage driven by band_enable
  localparam int BAND_FIRST_STAGE = 2;

  // opcodes
  localparam logic [OPC_W-1:0] OP_PROCESS = 2'd0;
  localparam logic [OPC_W-1:0] OP_COEF    = 2'd1;
  localparam logic [OPC_W-1:0] OP_CLEAR   = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BYPASS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HP_EN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HP_DBL   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_EN  = 2'd3;

  // coefficient slots
  localparam logic [SLOT_W-1:0] SLOT_B0 = 3'd0;
  localparam logic [SLOT_W-1:0] SLOT_B1 = 3'd1;
  localparam logic [SLOT_W-1:0] SLOT_B2 = 3'd2;
  localparam logic [SLOT_W-1:0] SLOT_A1 = 3'd3;
  localparam logic [SLOT_W-1:0] SLOT_A2 = 3'd4;

  // control from the sequencer to both lanes
  typedef struct packed {
    logic              load_x;
    logic              clr_hist;
    logic              hist_rd;
    logic              load_hist;
    logic              mul_en;
    logic [SLOT_W-1:0] mul_slot;
    logic              acc_clr;
    logic              acc_en;
    logic              wr_hist;
  } lane_ctl_t;

endpackage

// ===== rtl/core/sbeq_in_if.sv =====
interface sbeq_in_if #(
  parameter int SAMPLE_BITS = sbeq_pkg::SAMPLE_BITS_DEF
);
  logic                                 valid;
  logic                                 ready;
  logic [sbeq_pkg::OPC_W-1:0]           opcode;
  logic signed [SAMPLE_BITS-1:0]        left_in;
  logic signed [SAMPLE_BITS-1:0]        right_in;
  logic [sbeq_pkg::STAGE_W-1:0]         coef_stage;
  logic [sbeq_pkg::SLOT_W-1:0]          coef_slot;
  logic signed [sbeq_pkg::COEF_IN_W-1:0] coef_value;

  modport source (
    output valid, opcode, left_in, right_in, coef_stage, coef_slot, coef_value,
    input  ready
  );
  modport sink (
    input  valid, opcode, left_in, right_in, coef_stage, coef_slot, coef_value,
    output ready
  );
endinterface

// ===== rtl/core/sbeq_out_if.sv =====
interface sbeq_out_if #(
  parameter int SAMPLE_BITS = sbeq_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_out;
  logic signed [SAMPLE_BITS-1:0] right_out;

  modport source (output valid, left_out, right_out, input ready);
  modport sink (input valid, left_out, right_out, output ready);
endinterface

// ===== rtl/core/sbeq_ram.sv =====
module sbeq_ram #(
  parameter int W = 32,
  parameter int D = 8,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/sbeq_seq.sv =====
module sbeq_seq #(
  parameter int NUM_STAGES = sbeq_pkg::NUM_STAGES_DEF,
  localparam int HA_W = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1,
  localparam int CA_D = NUM_STAGES * sbeq_pkg::NUM_SLOTS,
  localparam int CA_W = (CA_D > 1) ? $clog2(CA_D) : 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  skip,
  input  logic                  clear,
  input  logic [NUM_STAGES-1:0] stage_en,
  input  logic                  out_free,
  output sbeq_pkg::lane_ctl_t   ctl,
  output logic [HA_W-1:0]       stage,
  output logic                  coef_rd,
  output logic [CA_W-1:0]       coef_raddr,
  output logic                  busy,
  output logic                  done_load
);
  import sbeq_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  // steps of one active stage
  localparam logic [2:0] STEP_ISSUE    = 3'd0;
  localparam logic [2:0] STEP_LOAD     = 3'd1;
  localparam logic [2:0] STEP_LAST_RD  = 3'd4;
  localparam logic [2:0] STEP_LAST_MUL = 3'd5;
  localparam logic [2:0] STEP_FIRST_AC = 3'd2;
  localparam logic [2:0] STEP_LAST_AC  = 3'd6;
  localparam logic [2:0] STEP_WB       = 3'd7;

  logic [1:0]      state_r, state_nxt;
  logic [HA_W-1:0] stg_r, stg_nxt;
  logic [2:0]      step_r, step_nxt;
  logic            stg_on;
  logic            last_stg;
  logic            run;

  assign stg_on   = stage_en[stg_r];
  assign last_stg = (stg_r == HA_W'(NUM_STAGES - 1));
  assign run      = (state_r == ST_RUN);
  assign stage    = stg_r;
  assign busy     = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    stg_nxt   = stg_r;
    step_nxt  = step_r;
    done_load = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        stg_nxt  = '0;
        step_nxt = STEP_ISSUE;
        if (start) begin
          state_nxt = skip ? ST_DONE : ST_RUN;
        end
      end
      ST_RUN: begin
        if ((step_r == STEP_ISSUE && !stg_on) || step_r == STEP_WB) begin
          step_nxt = STEP_ISSUE;
          if (last_stg) begin
            state_nxt = ST_DONE;
          end else begin
            stg_nxt = stg_r + 1'b1;
          end
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          done_load = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // later steps are only reached for an enabled stage
  always_comb begin
    ctl           = '0;
    ctl.load_x    = start;
    ctl.clr_hist  = clear;
    ctl.hist_rd   = run && step_r == STEP_ISSUE && stg_on;
    ctl.load_hist = run && step_r == STEP_LOAD;
    ctl.acc_clr   = run && step_r == STEP_LOAD;
    ctl.mul_en    = run && step_r >= STEP_LOAD && step_r <= STEP_LAST_MUL;
    ctl.mul_slot  = SLOT_W'(step_r - 3'd1);
    ctl.acc_en    = run && step_r >= STEP_FIRST_AC && step_r <= STEP_LAST_AC;
    ctl.wr_hist   = run && step_r == STEP_WB;
    coef_rd       = run && step_r <= STEP_LAST_RD && (step_r != STEP_ISSUE || stg_on);
    coef_raddr    = CA_W'(int'(stg_r) * NUM_SLOTS + int'(step_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      stg_r   <= '0;
      step_r  <= STEP_ISSUE;
    end else begin
      state_r <= state_nxt;
      stg_r   <= stg_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

// ===== rtl/core/sbeq_lane.sv =====
module sbeq_lane #(
  parameter int SAMPLE_BITS = sbeq_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_BITS   = sbeq_pkg::COEF_BITS_DEF,
  parameter int NUM_STAGES  = sbeq_pkg::NUM_STAGES_DEF,
  localparam int HA_W = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sbeq_pkg::lane_ctl_t           ctl,
  input  logic [HA_W-1:0]               hist_addr,
  input  logic signed [COEF_BITS-1:0]   coef,
  input  logic signed [SAMPLE_BITS-1:0] x_in,
  output logic signed [SAMPLE_BITS-1:0] y_out
);
  import sbeq_pkg::*;

  localparam int FRAC  = COEF_BITS - 4;
  localparam int PW    = COEF_BITS + SAMPLE_BITS;
  localparam int ACC_W = PW + 3;
  localparam int YW    = ACC_W - FRAC;
  localparam int RW    = 4 * SAMPLE_BITS;
  localparam logic signed [ACC_W-1:0] RND = ACC_W'(1) << (FRAC - 1);
  localparam logic signed [SAMPLE_BITS-1:0] MAXV = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] MINV = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic signed [SAMPLE_BITS-1:0] x_r, x1_r, x2_r, y1_r, y2_r;
  logic signed [SAMPLE_BITS-1:0] opnd;
  logic signed [PW-1:0]          prod_r, prod_nxt;
  logic                          sub_r;
  logic signed [ACC_W-1:0]       acc_r, acc_nxt;
  logic signed [YW-1:0]          y_full;
  logic [YW-SAMPLE_BITS:0]       y_top;
  logic signed [SAMPLE_BITS-1:0] y_sat;
  logic [NUM_STAGES-1:0]         hvld_r;
  logic                          hvld_rd_r;
  logic [RW-1:0]                 row_rd, row, row_wr;

  // row: x1 in the low word, then x2, y1, y2
  assign row    = hvld_rd_r ? row_rd : '0;
  assign row_wr = {y1_r, y_sat, x1_r, x_r};

  sbeq_ram #(.W(RW), .D(NUM_STAGES)) u_hist (
    .clk   (clk),
    .we    (ctl.wr_hist),
    .waddr (hist_addr),
    .wdata (row_wr),
    .re    (ctl.hist_rd),
    .raddr (hist_addr),
    .rdata (row_rd)
  );

  always_comb begin
    case (ctl.mul_slot)
      SLOT_B0: opnd = x_r;
      SLOT_B1: opnd = x1_r;
      SLOT_B2: opnd = x2_r;
      SLOT_A1: opnd = y1_r;
      SLOT_A2: opnd = y2_r;
      default: opnd = '0;
    endcase
  end

  assign prod_nxt = coef * opnd;
  assign acc_nxt  = sub_r ? acc_r - ACC_W'(prod_r) : acc_r + ACC_W'(prod_r);

  // round half up is already in the accumulator, floor shift and clamp
  assign y_full = YW'(acc_r >>> FRAC);
  assign y_top  = y_full[YW-1:SAMPLE_BITS-1];
  assign y_sat  = (&y_top || ~|y_top) ? y_full[SAMPLE_BITS-1:0]
                                      : (y_full[YW-1] ? MINV : MAXV);
  assign y_out  = x_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hvld_r    <= '0;
      hvld_rd_r <= 1'b0;
    end else begin
      if (ctl.clr_hist) begin
        hvld_r <= '0;
      end else if (ctl.wr_hist) begin
        hvld_r[hist_addr] <= 1'b1;
      end
      if (ctl.hist_rd) begin
        hvld_rd_r <= hvld_r[hist_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_x) begin
      x_r <= x_in;
    end else if (ctl.wr_hist) begin
      x_r <= y_sat;
    end
    if (ctl.load_hist) begin
      {y2_r, y1_r, x2_r, x1_r} <= row;
    end
    if (ctl.mul_en) begin
      prod_r <= prod_nxt;
      sub_r  <= (ctl.mul_slot == SLOT_A1) || (ctl.mul_slot == SLOT_A2);
    end
    if (ctl.acc_clr) begin
      acc_r <= RND;
    end else if (ctl.acc_en) begin
      acc_r <= acc_nxt;
    end
  end

endmodule

// ===== rtl/core/stereo_biquad_eq_cascade_core.sv =====
// Stereo biquad equalizer: up to seven Direct Form I stages per channel.
// in_ch carries one request per transfer: opcode process takes a sample
// pair and yields one pair on out_ch; write coefficient and clear history
// yield nothing. cfg_we/cfg_index/cfg_data set bypass,
// the high-pass enables and the band enables; write them while idle.
// Left and right each have a lane with its own 32x24 multiplier and
// history memory; both read the same coefficient from the shared store.
// A process request runs through the enabled stages in turn and passes
// over disabled ones; in bypass it skips all stages. For each enabled
// stage the history is read, the five products pass through each lane's
// multiplier, and the sum is accumulated and written back.
// in_ch.ready is high whenever no process request is in flight.
// The result sits in an output register; when out_ch stalls the next
// request is still taken and runs, and waits at the end until the
// register is free. Reset clears the control and valid registers, so all
// coefficients and all history read as zero; no memory word is cleared.
module stereo_biquad_eq_cascade_core #(
  parameter int SAMPLE_BITS = sbeq_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_BITS   = sbeq_pkg::COEF_BITS_DEF,
  parameter int NUM_STAGES  = sbeq_pkg::NUM_STAGES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  sbeq_in_if.sink                         in_ch,
  sbeq_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [sbeq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sbeq_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sbeq_pkg::*;

  localparam int HA_W = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;
  localparam int CA_D = NUM_STAGES * NUM_SLOTS;
  localparam int CA_W = (CA_D > 1) ? $clog2(CA_D) : 1;

  logic              bypass_r, hp_en_r, hp_dbl_r;
  logic [BAND_W-1:0] band_en_r;

  logic                  in_acc;
  logic                  is_proc, is_coef, is_clr;
  logic                  coef_ok, coef_we;
  logic [CA_W-1:0]       coef_waddr;
  logic [NUM_STAGES-1:0] stage_en;
  lane_ctl_t             ctl;
  logic [HA_W-1:0]       stage;
  logic                  coef_rd;
  logic [CA_W-1:0]       coef_raddr;
  logic [COEF_BITS-1:0]  coef_rdata;
  logic [CA_D-1:0]       cvld_r;
  logic                  cvld_rd_r;
  logic signed [COEF_BITS-1:0]   coef_q;
  logic                  busy, done_load, out_free;
  logic signed [SAMPLE_BITS-1:0] left_y, right_y;
  logic                  out_valid_r;
  logic signed [SAMPLE_BITS-1:0] left_r, right_r;

  assign in_ch.ready = !busy;
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_comb begin
    is_proc = 1'b0;
    is_coef = 1'b0;
    is_clr  = 1'b0;
    unique case (in_ch.opcode)
      OP_PROCESS: is_proc = 1'b1;
      OP_COEF:    is_coef = 1'b1;
      OP_CLEAR:   is_clr  = 1'b1;
      default:    ;
    endcase
  end

  // out of range coefficient addresses are dropped
  assign coef_ok    = (int'(in_ch.coef_stage) < NUM_STAGES)
                   && (in_ch.coef_slot < SLOT_W'(NUM_SLOTS));
  assign coef_we    = in_acc && is_coef && coef_ok;
  assign coef_waddr = CA_W'(int'(in_ch.coef_stage) * NUM_SLOTS + int'(in_ch.coef_slot));

  for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage_en
    if (s == 0) begin : g_hp1
      assign stage_en[s] = hp_en_r;
    end else if (s == 1) begin : g_hp2
      assign stage_en[s] = hp_en_r && hp_dbl_r;
    end else if (s < BAND_FIRST_STAGE + BAND_W) begin : g_band
      assign stage_en[s] = band_en_r[s - BAND_FIRST_STAGE];
    end else begin : g_off
      assign stage_en[s] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bypass_r  <= 1'b0;
      hp_en_r   <= 1'b0;
      hp_dbl_r  <= 1'b0;
      band_en_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BYPASS:  bypass_r  <= cfg_data[0];
        REG_HP_EN:   hp_en_r   <= cfg_data[0];
        REG_HP_DBL:  hp_dbl_r  <= cfg_data[0];
        REG_BAND_EN: band_en_r <= cfg_data[BAND_W-1:0];
        default:     ;
      endcase
    end
  end

  sbeq_ram #(.W(COEF_BITS), .D(CA_D)) u_coef (
    .clk   (clk),
    .we    (coef_we),
    .waddr (coef_waddr),
    .wdata (in_ch.coef_value[COEF_BITS-1:0]),
    .re    (coef_rd),
    .raddr (coef_raddr),
    .rdata (coef_rdata)
  );

  // unwritten coefficients read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cvld_r    <= '0;
      cvld_rd_r <= 1'b0;
    end else begin
      if (coef_we) begin
        cvld_r[coef_waddr] <= 1'b1;
      end
      if (coef_rd) begin
        cvld_rd_r <= cvld_r[coef_raddr];
      end
    end
  end

  assign coef_q = cvld_rd_r ? $signed(coef_rdata) : '0;

  sbeq_seq #(.NUM_STAGES(NUM_STAGES)) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (in_acc && is_proc),
    .skip       (bypass_r),
    .clear      (in_acc && is_clr),
    .stage_en   (stage_en),
    .out_free   (out_free),
    .ctl        (ctl),
    .stage      (stage),
    .coef_rd    (coef_rd),
    .coef_raddr (coef_raddr),
    .busy       (busy),
    .done_load  (done_load)
  );

  sbeq_lane #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEF_BITS   (COEF_BITS),
    .NUM_STAGES  (NUM_STAGES)
  ) u_lane_l (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .hist_addr (stage),
    .coef      (coef_q),
    .x_in      (in_ch.left_in),
    .y_out     (left_y)
  );

  sbeq_lane #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEF_BITS   (COEF_BITS),
    .NUM_STAGES  (NUM_STAGES)
  ) u_lane_r (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .hist_addr (stage),
    .coef      (coef_q),
    .x_in      (in_ch.right_in),
    .y_out     (right_y)
  );

  // merge the two lanes into the result register
  assign out_free = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_load) begin
      left_r  <= left_y;
      right_r <= right_y;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.left_out  = left_r;
  assign out_ch.right_out = right_r;

endmodule

// ===== tb/eq_pair_checker.sv =====
`timescale 1ns / 100ps

module eq_pair_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  sbeq_in_if                              in_mon,
  sbeq_out_if                             out_mon,
  input  logic                            cfg_we,
  input  logic [sbeq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sbeq_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              mismatch_count,
  output int                              pending_pairs
);
  import sbeq_pkg::*;

  localparam int SB         = SAMPLE_BITS_DEF;
  localparam int CB         = COEF_BITS_DEF;
  localparam int NS         = NUM_STAGES_DEF;
  localparam int FRAC_SHIFT = CB - 4;

  localparam longint SAMPLE_MAX = (longint'(1) <<< (SB - 1)) - 1;
  localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

  // history slots and lanes
  localparam int X1 = 0;
  localparam int X2 = 1;
  localparam int Y1 = 2;
  localparam int Y2 = 3;
  localparam int LEFT  = 0;
  localparam int RIGHT = 1;

  typedef struct {
    logic signed [SB-1:0] left;
    logic signed [SB-1:0] right;
  } eq_pair_t;

  logic signed [CB-1:0] coef_mem [NS][NUM_SLOTS];
  logic signed [SB-1:0] hist [NS][2][4];
  logic                 bypass_on;
  logic                 hp_en;
  logic                 hp_dbl;
  logic [BAND_W-1:0]    band_en;

  eq_pair_t filtered_pairs [$];

  initial mismatch_count = 0;

  function automatic void clear_history();
    for (int s = 0; s < NS; s++)
      for (int c = 0; c < 2; c++)
        for (int k = 0; k < 4; k++)
          hist[s][c][k] = '0;
  endfunction

  function automatic logic stage_active(int s);
    if (s == 0) return hp_en;
    if (s == 1) return hp_en && hp_dbl;
    if (s >= BAND_FIRST_STAGE && s < BAND_FIRST_STAGE + BAND_W)
      return band_en[s - BAND_FIRST_STAGE];
    return 1'b0;
  endfunction

  // one direct form I section, exact products, round half up, clamp
  function automatic logic signed [SB-1:0] run_biquad(int s, int ch,
                                                      logic signed [SB-1:0] x);
    longint acc;
    longint y;
    acc = longint'(coef_mem[s][SLOT_B0]) * longint'(x)
        + longint'(coef_mem[s][SLOT_B1]) * longint'(hist[s][ch][X1])
        + longint'(coef_mem[s][SLOT_B2]) * longint'(hist[s][ch][X2])
        - longint'(coef_mem[s][SLOT_A1]) * longint'(hist[s][ch][Y1])
        - longint'(coef_mem[s][SLOT_A2]) * longint'(hist[s][ch][Y2])
        + (longint'(1) <<< (FRAC_SHIFT - 1));
    y = acc >>> FRAC_SHIFT;
    if (y > SAMPLE_MAX) y = SAMPLE_MAX;
    if (y < SAMPLE_MIN) y = SAMPLE_MIN;
    hist[s][ch][X2] = hist[s][ch][X1];
    hist[s][ch][X1] = x;
    hist[s][ch][Y2] = hist[s][ch][Y1];
    hist[s][ch][Y1] = y[SB-1:0];
    return y[SB-1:0];
  endfunction

  function automatic eq_pair_t equalize_pair(logic signed [SB-1:0] l,
                                             logic signed [SB-1:0] r);
    eq_pair_t p;
    p.left  = l;
    p.right = r;
    if (!bypass_on) begin
      for (int s = 0; s < NS; s++) begin
        if (stage_active(s)) begin
          p.left  = run_biquad(s, LEFT, p.left);
          p.right = run_biquad(s, RIGHT, p.right);
        end
      end
    end
    return p;
  endfunction

  always @(posedge clk) begin
    eq_pair_t want;
    if (!rst_n) begin
      for (int s = 0; s < NS; s++)
        for (int k = 0; k < NUM_SLOTS; k++)
          coef_mem[s][k] = '0;
      clear_history();
      bypass_on = 1'b0;
      hp_en     = 1'b0;
      hp_dbl    = 1'b0;
      band_en   = '0;
      filtered_pairs.delete();
      pending_pairs <= 0;
    end else begin
      // outputs first: a pair cannot leave in the cycle its request arrives
      if (out_mon.valid && out_mon.ready) begin
        if (filtered_pairs.size() == 0) begin
          $error("result with no pair expected: left_out %0d right_out %0d",
                 out_mon.left_out, out_mon.right_out);
          mismatch_count++;
        end else begin
          want = filtered_pairs.pop_front();
          if (out_mon.left_out !== want.left) begin
            $error("left_out mismatch: expected %0d, actual %0d",
                   want.left, out_mon.left_out);
            mismatch_count++;
          end
          if (out_mon.right_out !== want.right) begin
            $error("right_out mismatch: expected %0d, actual %0d",
                   want.right, out_mon.right_out);
            mismatch_count++;
          end
        end
      end

      if (cfg_we) begin
        case (cfg_index)
          REG_BYPASS:  bypass_on = cfg_data[0];
          REG_HP_EN:   hp_en     = cfg_data[0];
          REG_HP_DBL:  hp_dbl    = cfg_data[0];
          REG_BAND_EN: band_en   = cfg_data[BAND_W-1:0];
          default: ;
        endcase
      end

      if (in_mon.valid && in_mon.ready) begin
        case (in_mon.opcode)
          OP_PROCESS:
            filtered_pairs.push_back(equalize_pair(in_mon.left_in, in_mon.right_in));
          OP_COEF:
            if (in_mon.coef_stage < NS && in_mon.coef_slot < NUM_SLOTS)
              coef_mem[in_mon.coef_stage][in_mon.coef_slot] = in_mon.coef_value[CB-1:0];
          OP_CLEAR:
            clear_history();
          default: ;
        endcase
      end

      pending_pairs <= filtered_pairs.size();
    end
  end

endmodule

// ===== tb/tb_stereo_biquad_eq_cascade_core.sv =====
`timescale 1ns / 100ps

module tb_stereo_biquad_eq_cascade_core;
  import sbeq_pkg::*;

  localparam int SB            = SAMPLE_BITS_DEF;
  localparam int RANDOM_ITEMS  = 1200;
  localparam int SETTLE_CYCLES = 80;
  localparam int CYCLE_LIMIT   = 2000000;

  localparam logic [OPC_W-1:0] OP_UNUSED = 2'd3;

  localparam logic signed [SB-1:0]        S_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0]        S_MIN = {1'b1, {(SB-1){1'b0}}};
  localparam logic signed [COEF_IN_W-1:0] C_MAX = 32'h7fff_ffff;
  localparam logic signed [COEF_IN_W-1:0] C_MIN = 32'h8000_0000;
  localparam int                          UNITY = 1 << 28;

  typedef struct {
    logic [OPC_W-1:0]            opcode;
    logic signed [SB-1:0]        left;
    logic signed [SB-1:0]        right;
    logic [STAGE_W-1:0]          stage;
    logic [SLOT_W-1:0]           slot;
    logic signed [COEF_IN_W-1:0] value;
  } eq_req_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    mismatch_count;
  int                    pending_pairs;
  int                    cycle_count = 0;
  int                    counted_items;
  logic                  calm;

  sbeq_in_if  in_ch ();
  sbeq_out_if out_ch ();

  stereo_biquad_eq_cascade_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  eq_pair_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .pending_pairs  (pending_pairs)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 16);
    return $urandom_range(40, 150);
  endfunction

  function automatic int srand_span(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic logic signed [SB-1:0] rand_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return SB'($urandom);
    if (r < 8) return SB'(srand_span(1 << 18));
    case ($urandom_range(0, 5))
      0: return S_MAX;
      1: return S_MIN;
      2: return SB'(S_MAX - 1);
      3: return SB'(S_MIN + 1);
      4: return '0;
      default: return '1;
    endcase
  endfunction

  // coefficients that keep a section stable when written one at a time
  function automatic logic signed [COEF_IN_W-1:0] gentle_coef(logic [SLOT_W-1:0] slot);
    case (slot)
      SLOT_B0: return UNITY + srand_span(1 << 26);
      SLOT_B1: return srand_span(1 << 28);
      default: return srand_span(1 << 27);
    endcase
  endfunction

  function automatic eq_req_t make_req(logic [OPC_W-1:0] op, logic signed [SB-1:0] l,
                                       logic signed [SB-1:0] r, logic [STAGE_W-1:0] st,
                                       logic [SLOT_W-1:0] sl,
                                       logic signed [COEF_IN_W-1:0] v);
    eq_req_t q;
    q.opcode = op;
    q.left   = l;
    q.right  = r;
    q.stage  = st;
    q.slot   = sl;
    q.value  = v;
    return q;
  endfunction

  function automatic eq_req_t random_req();
    eq_req_t q;
    int r;
    q = make_req(OP_PROCESS, rand_sample(), rand_sample(), 3'($urandom),
                 3'($urandom), $urandom);
    r = $urandom_range(0, 99);
    if (r < 78) begin
      if ($urandom_range(0, 7) == 0) q.right = q.left;
    end else if (r < 88) begin
      q.opcode = OP_COEF;
      if ($urandom_range(0, 3) != 0) begin
        q.stage = STAGE_W'($urandom_range(0, NUM_STAGES_DEF - 1));
        q.slot  = SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
        if ($urandom_range(0, 9) < 7) q.value = gentle_coef(q.slot);
      end
    end else if (r < 94) begin
      q.opcode = OP_CLEAR;
    end else begin
      q.opcode = OP_UNUSED;
    end
    return q;
  endfunction

  task automatic send_req(input eq_req_t q);
    int g;
    in_ch.valid      <= 1'b1;
    in_ch.opcode     <= q.opcode;
    in_ch.left_in    <= q.left;
    in_ch.right_in   <= q.right;
    in_ch.coef_stage <= q.stage;
    in_ch.coef_slot  <= q.slot;
    in_ch.coef_value <= q.value;
    do @(posedge clk); while (!in_ch.ready);
    if (!(q.opcode == OP_UNUSED ||
          (q.opcode == OP_COEF && (q.stage >= NUM_STAGES_DEF || q.slot >= NUM_SLOTS))))
      counted_items++;
    g = calm ? 0 : gap_len();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic send_pair(input logic signed [SB-1:0] l, input logic signed [SB-1:0] r);
    send_req(make_req(OP_PROCESS, l, r, 3'($urandom), 3'($urandom), $urandom));
  endtask

  task automatic send_coef(input int st, input int sl, input logic signed [COEF_IN_W-1:0] v);
    send_req(make_req(OP_COEF, rand_sample(), rand_sample(), STAGE_W'(st), SLOT_W'(sl), v));
  endtask

  task automatic send_clear();
    send_req(make_req(OP_CLEAR, rand_sample(), rand_sample(), 3'($urandom),
                      3'($urandom), $urandom));
  endtask

  // wait out every pair, then let a trailing write or clear finish
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_pairs != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one-bit registers get random upper bits, the block should mask them
  task automatic write_config(input logic byp, input logic hpe, input logic hpd,
                              input logic [BAND_W-1:0] bands);
    logic [CFG_IDX_W-1:0]  idx [4];
    logic [CFG_DATA_W-1:0] val [4];
    idx[0] = REG_BYPASS;
    idx[1] = REG_HP_EN;
    idx[2] = REG_HP_DBL;
    idx[3] = REG_BAND_EN;
    val[0] = {4'($urandom), byp};
    val[1] = {4'($urandom), hpe};
    val[2] = {4'($urandom), hpd};
    val[3] = bands;
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic program_stage(input int st, input logic wild);
    for (int sl = 0; sl < NUM_SLOTS; sl++)
      send_coef(st, sl, wild ? $urandom : gentle_coef(SLOT_W'(sl)));
  endtask

  initial begin
    int stall_left;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if (!calm && $urandom_range(0, 3) == 0) stall_left = gap_len();
      end
    end
  end

  initial begin
    int phase;
    int n;
    calm             = 1'b0;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    in_ch.valid      = 1'b0;
    in_ch.opcode     = OP_PROCESS;
    in_ch.left_in    = '0;
    in_ch.right_in   = '0;
    in_ch.coef_stage = '0;
    in_ch.coef_slot  = '0;
    in_ch.coef_value = '0;
    counted_items    = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: no stage on, samples pass as they are
    write_config(1'b0, 1'b0, 1'b0, '0);
    send_pair(S_MAX, S_MIN);
    send_pair(S_MIN, S_MAX);
    send_req(make_req(OP_UNUSED, S_MAX, S_MIN, 3'd7, 3'd7, C_MIN));
    // bad coefficient addresses are dropped
    send_coef(7, SLOT_B0, C_MAX);
    send_coef(0, 5, C_MAX);
    send_coef(6, 7, C_MIN);
    // extreme coefficients in the first high-pass
    send_coef(0, SLOT_B0, C_MAX);
    send_coef(0, SLOT_B1, C_MIN);
    send_coef(0, SLOT_B2, UNITY);
    send_coef(0, SLOT_A1, -UNITY);
    send_coef(0, SLOT_A2, C_MAX);
    drain();
    write_config(1'b0, 1'b1, 1'b1, '1);
    send_pair(S_MAX, S_MAX);
    send_pair(S_MIN, S_MIN);
    send_pair('0, '1);
    send_clear();
    send_pair(SB'(1), SB'(-1));
    drain();
    // bypass keeps history; writes and clears still act
    write_config(1'b1, 1'b0, 1'b1, 5'h15);
    send_pair(S_MAX, S_MIN);
    send_coef(1, SLOT_B0, UNITY);
    send_clear();
    send_pair(rand_sample(), rand_sample());
    drain();
    write_config(1'b0, 1'b1, 1'b0, '0);
    send_pair(S_MAX, S_MIN);
    send_pair(S_MIN, S_MAX);
    send_pair('1, SB'(1));

    // random phases
    counted_items = 0;
    phase = 0;
    while (counted_items < RANDOM_ITEMS) begin
      drain();
      calm = (phase % 4 == 3);
      case (phase % 6)
        0: write_config(1'b0, 1'b1, 1'b1, '1);
        1: write_config(1'b0, 1'b0, 1'b0, '0);
        2: write_config(1'b1, 1'($urandom), 1'($urandom), 5'($urandom));
        default:
          write_config($urandom_range(0, 7) == 0, 1'($urandom), 1'($urandom),
                       5'($urandom));
      endcase
      for (int st = 0; st < NUM_STAGES_DEF; st++)
        if (phase == 0 || $urandom_range(0, 3) == 0)
          program_stage(st, $urandom_range(0, 5) == 0);
      if ($urandom_range(0, 2) == 0) send_clear();
      n = $urandom_range(8, 60);
      repeat (n) send_req(random_req());
      phase++;
    end

    drain();
    if (mismatch_count == 0 && pending_pairs == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/sbeq_pkg.sv
rtl/core/sbeq_in_if.sv
rtl/core/sbeq_out_if.sv
rtl/core/sbeq_ram.sv
rtl/core/sbeq_seq.sv
rtl/core/sbeq_lane.sv
rtl/core/stereo_biquad_eq_cascade_core.sv
tb/eq_pair_checker.sv
tb/tb_stereo_biquad_eq_cascade_core.sv
